>>> hdl/clt_pkg.sv
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types, widths and codes of the checkpoint lap timer.
// ----------------------------------------------------------------------------
package clt_pkg;

  localparam int unsigned CLT_MAX_CP   = 16;
  localparam int unsigned COORD_W      = 32;
  localparam int unsigned DIFF_W       = COORD_W + 1;
  localparam int unsigned PROD_W       = 2 * DIFF_W;
  localparam int unsigned TIME_W       = 48;
  localparam int unsigned IDX_W        = 4;
  localparam int unsigned CNT_W        = 5;
  localparam int unsigned EV_W         = 3;
  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(4);

  typedef enum logic {
    OP_POS   = 1'b0,
    OP_WRITE = 1'b1
  } clt_op_e;

  typedef enum logic [EV_W-1:0] {
    EV_NONE       = 3'd0,
    EV_LAP_START  = 3'd1,
    EV_SECTOR     = 3'd2,
    EV_LAP_DONE   = 3'd3,
    EV_IDLE_CROSS = 3'd4
  } clt_event_e;

  typedef enum logic [1:0] {
    ORI_COLLINEAR = 2'd0,
    ORI_CW        = 2'd1,
    ORI_CCW       = 2'd2
  } clt_ori_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_WAIT,
    ST_FIN
  } clt_state_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] slat;
    logic signed [COORD_W-1:0] slon;
    logic signed [COORD_W-1:0] elat;
    logic signed [COORD_W-1:0] elon;
  } clt_line_t;

  // control that travels with each operand pair into the product unit
  typedef struct packed {
    logic valid;
    logic second;
  } clt_mul_ctl_t;

endpackage

>>> hdl/clt_orient_unit.sv
// ----------------------------------------------------------------------------
// clt_orient_unit
// Shared 33x33 signed multiplier and compare: two products per orientation.
// ----------------------------------------------------------------------------
module clt_orient_unit import clt_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  clt_mul_ctl_t             ctl_i,
  input  logic signed [DIFF_W-1:0] a_i,
  input  logic signed [DIFF_W-1:0] b_i,
  output logic                     ori_valid_o,
  output clt_ori_e                 ori_o
);

  clt_mul_ctl_t             ctl1_q, ctl2_q;
  logic signed [DIFF_W-1:0] a_q, b_q;
  logic signed [PROD_W-1:0] prod_d, prod_q, hold_q;

  assign prod_d = a_q * b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_i;
    b_q    <= b_i;
    prod_q <= prod_d;
    // first product of the pair waits for the second
    if (ctl2_q.valid && !ctl2_q.second) begin
      hold_q <= prod_q;
    end
  end

  always_comb begin
    ori_valid_o = ctl2_q.valid && ctl2_q.second;
    if (hold_q > prod_q) begin
      ori_o = ORI_CW;
    end else if (hold_q < prod_q) begin
      ori_o = ORI_CCW;
    end else begin
      ori_o = ORI_COLLINEAR;
    end
  end

endmodule

>>> hdl/checkpoint_lap_timer.sv
// ----------------------------------------------------------------------------
// checkpoint_lap_timer
// Lap timer that tests each path segment against the next checkpoint line.
// ----------------------------------------------------------------------------
// A table write (op 1) is taken while idle; its all-zero result is strobed on
// res_valid_o in the next cycle and busy stays low. A position item (op 0)
// holds busy high; its result is strobed in the first cycle with busy low
// again. The busy phase covers the eight signed 33x33 products of the four
// orientation tests, one per cycle through a single multiplier, then its
// operand and product registers and the FIN state that updates the lap state.
// Every item gives exactly one result, shown for one cycle; the receiver
// cannot hold it off. The user writes checkpoints_in_use through cfg_we_i /
// cfg_data_i only while the block is idle; the block does not enforce it.
module checkpoint_lap_timer import clt_pkg::*; #(
  parameter int unsigned MAX_CHECKPOINTS = CLT_MAX_CP
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic                      op_i,
  input  logic signed [COORD_W-1:0] cur_lat_i,
  input  logic signed [COORD_W-1:0] cur_lon_i,
  input  logic signed [COORD_W-1:0] prev_lat_i,
  input  logic signed [COORD_W-1:0] prev_lon_i,
  input  logic [TIME_W-1:0]         time_us_i,
  input  logic [IDX_W-1:0]          cp_index_i,
  input  logic signed [COORD_W-1:0] cp_start_lat_i,
  input  logic signed [COORD_W-1:0] cp_start_lon_i,
  input  logic signed [COORD_W-1:0] cp_end_lat_i,
  input  logic signed [COORD_W-1:0] cp_end_lon_i,
  input  logic                      cfg_we_i,
  input  logic [CNT_W-1:0]          cfg_data_i,
  output logic                      res_valid_o,
  output logic [EV_W-1:0]           event_res_o,
  output logic [IDX_W-1:0]          crossed_index_o,
  output logic [TIME_W-1:0]         sector_time_us_o,
  output logic [TIME_W-1:0]         lap_time_us_o
);

  localparam int unsigned AW = (MAX_CHECKPOINTS > 1) ? $clog2(MAX_CHECKPOINTS) : 1;
  localparam int unsigned CW = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;

  clt_state_e state_q, state_d;
  logic [2:0] step_q, step_d;
  logic [1:0] ocnt_q, ocnt_d;
  logic [7:0] ori_q, ori_d;

  logic [CNT_W-1:0]  cfg_q;
  logic [AW-1:0]     nt_q, nt_d;
  logic              racing_q, racing_d;
  logic [TIME_W-1:0] lap_stamp_q, lap_stamp_d;
  logic [TIME_W-1:0] last_stamp_q, last_stamp_d;

  logic signed [COORD_W-1:0] cur_lat_q, cur_lon_q, prev_lat_q, prev_lon_q;
  logic [TIME_W-1:0]         time_q;

  clt_line_t table_q [MAX_CHECKPOINTS];
  clt_line_t line_q;

  logic              accept, wr_item, wr_ok;
  clt_mul_ctl_t      mul_ctl;
  logic signed [DIFF_W-1:0] a_d, b_d;
  logic              ori_valid;
  clt_ori_e          ori;

  logic              res_valid_q, res_valid_d;
  logic [EV_W-1:0]   ev_q, ev_d;
  logic [IDX_W-1:0]  cidx_q, cidx_d;
  logic [TIME_W-1:0] sect_q, sect_d;
  logic [TIME_W-1:0] lap_q, lap_d;

  logic signed [COORD_W-1:0] p_lat, p_lon, q_lat, q_lon, r_lat, r_lon;
  logic              crossed;
  logic [CW-1:0]     nxt, cnt;

  assign accept  = start && (state_q == ST_IDLE);
  assign wr_item = accept && (op_i == OP_WRITE);
  assign wr_ok   = 32'(cp_index_i) < 32'(MAX_CHECKPOINTS);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && op_i == OP_POS) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        if (step_q == 3'd7) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (ori_valid && ocnt_q == 2'd3) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    busy           = (state_q != ST_IDLE);
    mul_ctl.valid  = (state_q == ST_CALC);
    mul_ctl.second = step_q[0];
    step_d         = (state_q == ST_CALC) ? step_q + 3'd1 : '0;
    ocnt_d         = ocnt_q;
    ori_d          = ori_q;
    if (accept) begin
      ocnt_d = '0;
    end else if (ori_valid) begin
      ocnt_d = ocnt_q + 2'd1;
      ori_d  = {ori_q[5:0], ori};
    end
  end

  // operand select: orient(p, q, r) for prev-cur vs start, end, then line vs prev, cur
  always_comb begin
    case (step_q[2:1])
      2'd0: begin
        p_lat = prev_lat_q;  p_lon = prev_lon_q;
        q_lat = cur_lat_q;   q_lon = cur_lon_q;
        r_lat = line_q.slat; r_lon = line_q.slon;
      end
      2'd1: begin
        p_lat = prev_lat_q;  p_lon = prev_lon_q;
        q_lat = cur_lat_q;   q_lon = cur_lon_q;
        r_lat = line_q.elat; r_lon = line_q.elon;
      end
      2'd2: begin
        p_lat = line_q.slat; p_lon = line_q.slon;
        q_lat = line_q.elat; q_lon = line_q.elon;
        r_lat = prev_lat_q;  r_lon = prev_lon_q;
      end
      default: begin
        p_lat = line_q.slat; p_lon = line_q.slon;
        q_lat = line_q.elat; q_lon = line_q.elon;
        r_lat = cur_lat_q;   r_lon = cur_lon_q;
      end
    endcase
    if (step_q[0]) begin
      a_d = DIFF_W'(q_lat) - DIFF_W'(p_lat);
      b_d = DIFF_W'(r_lon) - DIFF_W'(q_lon);
    end else begin
      a_d = DIFF_W'(q_lon) - DIFF_W'(p_lon);
      b_d = DIFF_W'(r_lat) - DIFF_W'(q_lat);
    end
  end

  clt_orient_unit u_orient (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (mul_ctl),
    .a_i        (a_d),
    .b_i        (b_d),
    .ori_valid_o(ori_valid),
    .ori_o      (ori)
  );

  // lap state and result
  always_comb begin
    crossed      = (ori_q[7:6] != ori_q[5:4]) && (ori_q[3:2] != ori_q[1:0]);
    nxt          = CW'(nt_q) + CW'(1);
    cnt          = (CW'(cfg_q) > CW'(MAX_CHECKPOINTS)) ? CW'(MAX_CHECKPOINTS) : CW'(cfg_q);
    nt_d         = nt_q;
    racing_d     = racing_q;
    lap_stamp_d  = lap_stamp_q;
    last_stamp_d = last_stamp_q;
    res_valid_d  = 1'b0;
    ev_d         = EV_NONE;
    cidx_d       = '0;
    sect_d       = '0;
    lap_d        = '0;
    if (wr_item) begin
      res_valid_d = 1'b1;
    end else if (state_q == ST_FIN) begin
      res_valid_d = 1'b1;
      if (crossed) begin
        cidx_d = IDX_W'(nt_q);
        nt_d   = (nxt >= cnt) ? '0 : AW'(nxt);
        if (nt_q == '0) begin
          if (!racing_q) begin
            ev_d     = EV_LAP_START;
            racing_d = 1'b1;
          end else begin
            ev_d   = EV_LAP_DONE;
            sect_d = time_q - last_stamp_q;
            lap_d  = time_q - lap_stamp_q;
          end
          lap_stamp_d  = time_q;
          last_stamp_d = time_q;
        end else if (racing_q) begin
          ev_d         = EV_SECTOR;
          sect_d       = time_q - last_stamp_q;
          lap_d        = time_q - lap_stamp_q;
          last_stamp_d = time_q;
        end else begin
          ev_d = EV_IDLE_CROSS;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      step_q       <= '0;
      ocnt_q       <= '0;
      ori_q        <= '0;
      cfg_q        <= CNT_RESET;
      nt_q         <= '0;
      racing_q     <= 1'b0;
      lap_stamp_q  <= '0;
      last_stamp_q <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      step_q       <= step_d;
      ocnt_q       <= ocnt_d;
      ori_q        <= ori_d;
      nt_q         <= nt_d;
      racing_q     <= racing_d;
      lap_stamp_q  <= lap_stamp_d;
      last_stamp_q <= last_stamp_d;
      res_valid_q  <= res_valid_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q   <= ev_d;
    cidx_q <= cidx_d;
    sect_q <= sect_d;
    lap_q  <= lap_d;
    if (accept) begin
      cur_lat_q  <= cur_lat_i;
      cur_lon_q  <= cur_lon_i;
      prev_lat_q <= prev_lat_i;
      prev_lon_q <= prev_lon_i;
      time_q     <= time_us_i;
    end
  end

  // checkpoint table: one write port, registered read of the current target
  always_ff @(posedge clk_i) begin
    if (wr_item && wr_ok) begin
      table_q[AW'(cp_index_i)] <= '{slat: cp_start_lat_i, slon: cp_start_lon_i,
                                    elat: cp_end_lat_i,   elon: cp_end_lon_i};
    end
    line_q <= table_q[nt_q];
  end

  assign res_valid_o      = res_valid_q;
  assign event_res_o      = ev_q;
  assign crossed_index_o  = cidx_q;
  assign sector_time_us_o = sect_q;
  assign lap_time_us_o    = lap_q;

endmodule

>>> hdl/clt_checker.sv
// ----------------------------------------------------------------------------
// clt_checker
// Port-level checks of the checkpoint lap timer, bound to the top level.
// ----------------------------------------------------------------------------
module clt_checker import clt_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input logic                      op_i,
  input logic                      res_valid_o,
  input logic [EV_W-1:0]           event_res_o,
  input logic [IDX_W-1:0]          crossed_index_o,
  input logic [TIME_W-1:0]         sector_time_us_o,
  input logic [TIME_W-1:0]         lap_time_us_o
);

  // a table write answers in the next cycle with an empty result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && op_i == OP_WRITE |=> res_valid_o && event_res_o == EV_NONE)
    else $error("table write item gave no empty result");

  // a position item keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && op_i == OP_POS |=> busy && !res_valid_o)
    else $error("position item did not start a busy phase");

  // an empty result (no crossing) carries all-zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && event_res_o == EV_NONE |->
      crossed_index_o == '0 && sector_time_us_o == '0 && lap_time_us_o == '0)
    else $error("empty result with nonzero fields");

  // lap start and idle crossing report no times
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (event_res_o == EV_LAP_START || event_res_o == EV_IDLE_CROSS) |->
      sector_time_us_o == '0 && lap_time_us_o == '0)
    else $error("lap start or idle crossing with nonzero times");

  // a result while busy cannot come from a position item in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy && $past(busy) |-> !res_valid_o)
    else $error("result strobed in the middle of a position item");

endmodule

bind checkpoint_lap_timer clt_checker u_clt_checker (.*);
